FILE: rtl/epc_pkg.sv
// Package of types and constants for the event port controller.
`timescale 1ns / 1ps
package epc_pkg;
    localparam int NumPorts      = 16;
    localparam int PortW         = 4;
    localparam int OffDelayTicks = 40;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_SAMPLE = 3'd1,
        OP_RECV   = 3'd2,
        OP_TICK   = 3'd3,
        OP_EXPIRY = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        REG_NODE   = 3'd0,
        REG_SHORT  = 3'd1,
        REG_SOD    = 3'd2,
        REG_PULSE  = 3'd3,
        REG_PLONG  = 3'd4
    } reg_idx_t;

    localparam logic [0:0] KIND_EVENT = 1'b0;
    localparam logic [0:0] KIND_PIN   = 1'b1;

    localparam int FLAG_IN    = 0;
    localparam int FLAG_DELAY = 1;
    localparam int FLAG_INV   = 2;
    localparam int FLAG_PULSE = 3;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  port;
        logic        pin_level;
        logic        start_of_day;
        logic        tx_ready;
        logic [15:0] node;
        logic [15:0] address;
        logic        event_on;
        logic [3:0]  port_flags;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  event_code;
        logic [15:0] event_node;
        logic [15:0] event_address;
        logic [3:0]  out_port;
        logic        pin_value;
        logic        last;
    } result_t;

    // Port entry held in the table memory.
    typedef struct packed {
        logic [3:0]  flags;
        logic [15:0] address;
        logic [15:0] node;
        logic        status;
        logic        timed;
        logic [7:0]  timer;
    } entry_t;

    function automatic logic [7:0] pulse_ticks(input logic [1:0] sel, input logic lng);
        logic [7:0] b;
        begin
            unique case (sel)
                2'd0: b = 8'd5;
                2'd1: b = 8'd10;
                2'd2: b = 8'd20;
                default: b = 8'd40;
            endcase
            pulse_ticks = lng ? 8'((b << 2) + (b << 1)) : b;
        end
    endfunction
endpackage

FILE: rtl/epc_stream_if.sv
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface epc_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/epc_table.sv
// Port entry memory, one write and one registered read port.
`timescale 1ns / 1ps
module epc_table (
    input  logic                    clk,
    input  logic                    we,
    input  logic [epc_pkg::PortW-1:0] waddr,
    input  epc_pkg::entry_t         wdata,
    input  logic [epc_pkg::PortW-1:0] raddr,
    output epc_pkg::entry_t         rdata
);
    import epc_pkg::*;
    entry_t mem [NumPorts];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/event_port_controller.sv
// Top level of the event port controller.
`timescale 1ns / 1ps
// Sequencing: a load is written to the entry memory when it is accepted; a sample or expiry reads its
//   entry at acceptance and decides in the next cycle; a walk reads and then executes each port entry.
// Flow: a new item is taken only in idle, once the previous one is done with its walk, its pin
//   writes and any output stalls; results trail by one slot.
// Reset: the entry memory is swept to zero, entry by entry through all 16, after reset, during
//   which no transaction is taken; configuration registers clear at once.
module event_port_controller (
    input  logic clk,
    input  logic rst_n,
    epc_stream_if.sink   in_ch,
    epc_stream_if.source out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import epc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_PEXEC, S_WREAD, S_WEXEC, S_PUSH, S_FLUSH
    } state_t;

    state_t state_reg;
    logic [PortW-1:0] cnt_reg;      // sweep/walk index
    item_t item_reg;
    result_t res_reg;
    logic out_valid_reg;
    // Walk parameters
    logic [15:0] wnode_reg, waddr_reg;
    logic won_reg;
    result_t ev_reg;                 // pin write waiting for the hold slot
    // Hold one result back so that "last" is known when it leaves
    result_t hold_reg;
    logic hold_valid_reg;

    // Configuration
    logic [15:0] node_number_reg;
    logic short_reg, sod_all_reg, plong_reg;
    logic [1:0] psel_reg;

    logic we;
    logic [PortW-1:0] wa, ra;
    entry_t wd, rd;

    epc_table u_table (.clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_number_reg <= '0;
            short_reg <= 1'b0;
            sod_all_reg <= 1'b0;
            psel_reg <= '0;
            plong_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODE:  node_number_reg <= cfg_data;
                REG_SHORT: short_reg <= cfg_data[0];
                REG_SOD:   sod_all_reg <= cfg_data[0];
                REG_PULSE: psel_reg <= cfg_data[1:0];
                REG_PLONG: plong_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Output register frees when empty or taken
    logic out_free, out_push;
    result_t out_next;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign out_push = (state_reg == S_PUSH || state_reg == S_FLUSH) && hold_valid_reg
                      && out_free;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = res_reg;

    // The held result is the last one only when it leaves in the flush step
    always_comb
    begin
        out_next = hold_reg;
        out_next.last = (state_reg == S_FLUSH);
    end

    logic [PortW-1:0] idx;
    assign idx = cnt_reg;
    assign ra = (state_reg == S_IDLE) ? in_ch.data.port : idx;

    // Per-entry decisions from the read data
    logic pval, m_hit, v_bit;
    logic sod, s_on, s_fire, x_due;
    assign sod = item_reg.start_of_day;
    assign pval = !item_reg.pin_level;
    assign m_hit = !rd.flags[FLAG_IN] && rd.address == waddr_reg
                   && (short_reg || rd.node == wnode_reg);
    assign v_bit = won_reg ^ rd.flags[FLAG_INV];
    assign s_on = pval ^ rd.flags[FLAG_INV];
    // A sample that reports (not absorbed by the off delay)
    assign s_fire = rd.flags[FLAG_IN] && (sod || pval != rd.status)
                    && !(!sod && rd.flags[FLAG_DELAY] && !pval)
                    && !(!sod && rd.flags[FLAG_DELAY] && rd.timed);
    assign x_due = rd.timed && rd.timer == 8'd0;

    function automatic result_t mk_event(input logic on, input logic sodf,
                                         input logic sh, input logic [15:0] nn,
                                         input logic [15:0] a);
        result_t r;
        begin
            r = '0;
            r.kind = KIND_EVENT;
            r.event_code = {sh && !sodf, !on};
            r.event_node = nn;
            r.event_address = a;
            mk_event = r;
        end
    endfunction

    function automatic result_t mk_pin(input logic [PortW-1:0] p, input logic v);
        result_t r;
        begin
            r = '0;
            r.kind = KIND_PIN;
            r.out_port = p;
            r.pin_value = v;
            mk_pin = r;
        end
    endfunction

    // Memory write
    always_comb
    begin
        we = 1'b0;
        wa = idx;
        wd = rd;
        unique case (state_reg)
            S_CLEAR: begin we = 1'b1; wd = '0; end
            S_IDLE: begin
                if (in_ch.valid && in_ch.data.op == OP_LOAD)
                begin
                    we = 1'b1;
                    wa = in_ch.data.port;
                    wd = '0;
                    wd.flags = in_ch.data.port_flags;
                    wd.address = in_ch.data.address;
                    wd.node = in_ch.data.node;
                end
            end
            S_PEXEC: begin
                wa = item_reg.port;
                if (item_reg.op == OP_SAMPLE)
                begin
                    if (rd.flags[FLAG_IN] && (sod || pval != rd.status))
                    begin
                        we = 1'b1;
                        wd.status = pval;
                        if (!sod && rd.flags[FLAG_DELAY] && !pval)
                        begin
                            wd.timer = 8'(OffDelayTicks);
                            wd.timed = 1'b1;
                        end
                        else if (!sod && rd.flags[FLAG_DELAY] && rd.timed)
                        begin
                            wd.timer = 8'(OffDelayTicks);
                            wd.timed = 1'b0;
                        end
                        else if (!(sod && !sod_all_reg && !(pval ^ rd.flags[FLAG_INV]))
                                 && !item_reg.tx_ready)
                        begin
                            wd.status = !pval;
                        end
                    end
                end
                else if (rd.timed && rd.timer == 8'd0)
                begin
                    we = 1'b1;
                    wd.timed = 1'b0;
                end
            end
            S_WEXEC: begin
                if (item_reg.op == OP_TICK)
                begin
                    we = rd.timed && rd.timer != 8'd0;
                    wd.timer = rd.timer - 8'd1;
                end
                else if (m_hit && v_bit && rd.flags[FLAG_PULSE])
                begin
                    we = 1'b1;
                    wd.timed = 1'b1;
                    wd.timer = pulse_ticks(psel_reg, plong_reg);
                end
            end
            default: ;
        endcase
    end

    // State advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
            item_reg <= '0;
            res_reg <= '0;
            out_valid_reg <= 1'b0;
            wnode_reg <= '0;
            waddr_reg <= '0;
            won_reg <= 1'b0;
            ev_reg <= '0;
            hold_reg <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_push)
            begin
                res_reg <= out_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    cnt_reg <= cnt_reg + PortW'(1);
                    if (idx == PortW'(NumPorts - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_ch.valid)
                    begin
                        item_reg <= in_ch.data;
                        cnt_reg <= '0;
                        wnode_reg <= in_ch.data.node;
                        waddr_reg <= in_ch.data.address;
                        won_reg <= in_ch.data.event_on;
                        unique case (in_ch.data.op)
                            OP_SAMPLE, OP_EXPIRY: state_reg <= S_PEXEC;
                            OP_RECV, OP_TICK: state_reg <= S_WREAD;
                            default: ;
                        endcase
                    end
                end
                S_PEXEC: begin
                    // Decide the single-port action; the entry was read at acceptance
                    wnode_reg <= node_number_reg;
                    waddr_reg <= rd.address;
                    if (item_reg.op == OP_SAMPLE && s_fire)
                    begin
                        won_reg <= s_on;
                        hold_reg <= mk_event(s_on, sod, short_reg, node_number_reg,
                                             rd.address);
                        hold_valid_reg <= item_reg.tx_ready
                                          && !(sod && !sod_all_reg && !s_on);
                        state_reg <= S_WREAD;
                    end
                    else if (item_reg.op != OP_SAMPLE && x_due && rd.flags[FLAG_IN])
                    begin
                        won_reg <= rd.flags[FLAG_INV];
                        hold_reg <= mk_event(rd.flags[FLAG_INV], 1'b0, short_reg,
                                             node_number_reg, rd.address);
                        hold_valid_reg <= item_reg.tx_ready;
                        state_reg <= S_WREAD;
                    end
                    else if (item_reg.op != OP_SAMPLE && x_due)
                    begin
                        hold_reg <= mk_pin(item_reg.port, 1'b0);
                        hold_valid_reg <= 1'b1;
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_WREAD: state_reg <= S_WEXEC;
                S_WEXEC: begin
                    if (item_reg.op != OP_TICK && m_hit)
                    begin
                        ev_reg <= mk_pin(idx, v_bit);
                        state_reg <= S_PUSH;
                    end
                    else if (idx == PortW'(NumPorts - 1))
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + PortW'(1);
                        state_reg <= S_WREAD;
                    end
                end
                S_PUSH: begin
                    // Move the held result out, then hold the new pin write
                    if (!hold_valid_reg || out_free)
                    begin
                        hold_reg <= ev_reg;
                        hold_valid_reg <= 1'b1;
                        if (idx == PortW'(NumPorts - 1))
                        begin
                            state_reg <= S_FLUSH;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + PortW'(1);
                            state_reg <= S_WREAD;
                        end
                    end
                end
                S_FLUSH: begin
                    // Release the held result marked last
                    if (!hold_valid_reg || out_free)
                    begin
                        hold_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |-> state_reg == S_IDLE)
        else $error("transaction taken outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !in_ch.ready)
        else $error("transaction taken during clearing sweep");
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> state_reg != S_IDLE)
        else $error("held result left behind");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("waiting result changed");
endmodule

FILE: test/epc_checker.sv
// Checker for the event port controller: watches both channels, predicts results and compares.
`timescale 1ns / 1ps
module epc_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  epc_pkg::item_t   in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  epc_pkg::result_t out_data,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output int               errors,
    output int               pending
);
    import epc_pkg::*;

    logic [3:0]  pt_flags [NumPorts];
    logic [15:0] pt_addr  [NumPorts];
    logic [15:0] pt_node  [NumPorts];
    logic        pt_stat  [NumPorts];
    logic        pt_timed [NumPorts];
    logic [7:0]  pt_timer [NumPorts];

    logic [15:0] own_node;
    logic        short_mode;
    logic        sod_all;
    logic [1:0]  pulse_sel;
    logic        pulse_x6;

    result_t     expected_q [$];
    result_t     step_q [$];

    task automatic push_result(input result_t r);
        if (step_q.size() < 17)
            step_q.push_back(r);
    endtask

    task automatic push_event(input logic on, input logic sod, input logic [15:0] addr);
        result_t r;
        r = '0;
        r.kind = KIND_EVENT;
        r.event_code = {short_mode && !sod, !on};
        r.event_node = own_node;
        r.event_address = addr;
        push_result(r);
    endtask

    task automatic drive_pins(input logic [15:0] nn, input logic [15:0] addr, input logic on);
        result_t    r;
        logic       v;
        logic [7:0] t;
        for (int i = 0; i < NumPorts; i++) begin
            if (pt_flags[i][FLAG_IN] || pt_addr[i] != addr)
                continue;
            if (!short_mode && pt_node[i] != nn)
                continue;
            v = on ^ pt_flags[i][FLAG_INV];
            r = '0;
            r.kind = KIND_PIN;
            r.out_port = i[3:0];
            r.pin_value = v;
            push_result(r);
            if (v && pt_flags[i][FLAG_PULSE]) begin
                case (pulse_sel)
                    2'd0: t = 8'd5;
                    2'd1: t = 8'd10;
                    2'd2: t = 8'd20;
                    default: t = 8'd40;
                endcase
                if (pulse_x6)
                    t = t * 8'd6;
                pt_timed[i] = 1'b1;
                pt_timer[i] = t;
            end
        end
    endtask

    task automatic predict_item(input item_t it);
        int         p;
        logic       val;
        logic       send;
        logic [3:0] f;
        p = it.port;
        f = pt_flags[p];
        step_q.delete();
        case (it.op)
            OP_LOAD:
            begin
                pt_flags[p] = it.port_flags;
                pt_addr[p]  = it.address;
                pt_node[p]  = it.node;
                pt_stat[p]  = 1'b0;
                pt_timed[p] = 1'b0;
                pt_timer[p] = '0;
            end
            OP_SAMPLE:
            begin
                val = !it.pin_level;
                if (f[FLAG_IN] && (it.start_of_day || val != pt_stat[p])) begin
                    pt_stat[p] = val;
                    if (!it.start_of_day && f[FLAG_DELAY] && !val) begin
                        pt_timer[p] = 8'(OffDelayTicks);
                        pt_timed[p] = 1'b1;
                    end
                    else if (!it.start_of_day && f[FLAG_DELAY] && pt_timed[p]) begin
                        pt_timer[p] = 8'(OffDelayTicks);
                        pt_timed[p] = 1'b0;
                    end
                    else begin
                        val = val ^ f[FLAG_INV];
                        send = !(it.start_of_day && !sod_all && !val);
                        if (send) begin
                            if (it.tx_ready)
                                push_event(val, it.start_of_day, pt_addr[p]);
                            else
                                pt_stat[p] = !pt_stat[p];
                        end
                        drive_pins(own_node, pt_addr[p], val);
                    end
                end
            end
            OP_RECV:
                drive_pins(it.node, it.address, it.event_on);
            OP_TICK:
                for (int i = 0; i < NumPorts; i++)
                    if (pt_timed[i] && pt_timer[i] > 0)
                        pt_timer[i] = pt_timer[i] - 8'd1;
            OP_EXPIRY:
                if (pt_timed[p] && pt_timer[p] == 0) begin
                    result_t r;
                    pt_timed[p] = 1'b0;
                    if (f[FLAG_IN]) begin
                        if (it.tx_ready)
                            push_event(f[FLAG_INV], 1'b0, pt_addr[p]);
                        drive_pins(own_node, pt_addr[p], f[FLAG_INV]);
                    end
                    else begin
                        r = '0;
                        r.kind = KIND_PIN;
                        r.out_port = p[3:0];
                        push_result(r);
                    end
                end
            default: ;
        endcase
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[k])
            expected_q.push_back(step_q[k]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NumPorts; i++) begin
                pt_flags[i] = '0;
                pt_addr[i]  = '0;
                pt_node[i]  = '0;
                pt_stat[i]  = 1'b0;
                pt_timed[i] = 1'b0;
                pt_timer[i] = '0;
            end
            own_node   = '0;
            short_mode = 1'b0;
            sod_all    = 1'b0;
            pulse_sel  = '0;
            pulse_x6   = 1'b0;
            errors     = 0;
            pending    = 0;
            expected_q.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_NODE:  own_node   = cfg_data;
                    REG_SHORT: short_mode = cfg_data[0];
                    REG_SOD:   sod_all    = cfg_data[0];
                    REG_PULSE: pulse_sel  = cfg_data[1:0];
                    REG_PLONG: pulse_x6   = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             out_data);
                    errors++;
                end
                else begin
                    result_t e;
                    e = expected_q.pop_front();
                    if (e.kind !== out_data.kind || e.event_code !== out_data.event_code
                        || e.event_node !== out_data.event_node
                        || e.event_address !== out_data.event_address
                        || e.out_port !== out_data.out_port
                        || e.pin_value !== out_data.pin_value
                        || e.last !== out_data.last) begin
                        $display("%0t: result mismatch, expected %h, actual %h", $time,
                                 e, out_data);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_item(in_data);
            pending = expected_q.size();
        end
    end
endmodule

FILE: test/tb_event_port_controller.sv
// Testbench top for the event port controller: stimulus, reset and verdict.
`timescale 1ns / 1ps
module tb_event_port_controller;
    import epc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    int          cycles;
    bit          hold_sink;   // raised while the receiver holds off for a long stretch
    bit          sink_run;

    epc_stream_if #(.payload_t(item_t))   in_ch ();
    epc_stream_if #(.payload_t(result_t)) out_ch ();

    event_port_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    epc_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: generous against the slowest run (17 results per item, each behind a random
    // receiver stall, plus the long hold-off and the reset sweep).
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver: random stall per transaction; a forced hold-off overrides it.
    initial begin
        int w;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_sink) begin
                out_ch.ready <= 1'b0;
            end
            else if (!out_ch.ready) begin
                w = sink_run ? 0 : $urandom_range(0, 3);
                repeat (w) @(negedge clk);
                if (!hold_sink)
                    out_ch.ready <= 1'b1;
            end
            else if (out_ch.valid) begin
                // Drop ready after an accepted transaction only when a stall is due.
                if (!sink_run && $urandom_range(0, 1) == 0)
                    out_ch.ready <= 1'b0;
            end
        end
    end

    // Offer one transaction; valid stays up for the next one when no gap is drawn.
    task automatic send_item(input item_t it, input bit no_gap);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (w != 0) begin
            in_ch.valid <= 1'b0;
            repeat (w) @(negedge clk);
        end
        in_ch.data  <= it;
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    function automatic item_t make_item(input op_t op, input int p);
        item_t it;
        it.op           = op;
        it.port         = p[3:0];
        it.pin_level    = 1'($urandom_range(0, 1));
        it.start_of_day = ($urandom_range(0, 5) == 0);
        it.tx_ready     = ($urandom_range(0, 4) != 0);
        it.node         = 16'($urandom_range(0, 3));
        it.address      = 16'($urandom_range(0, 3));
        it.event_on     = 1'($urandom_range(0, 1));
        it.port_flags   = 4'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drop valid, wait for every expected result, then let the block finish any silent item.
    task automatic drain;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] nn, input logic sh, input logic sa,
                              input logic [1:0] ps, input logic pl);
        drain();
        write_reg(REG_NODE, nn);
        write_reg(REG_SHORT, {15'd0, sh});
        write_reg(REG_SOD, {15'd0, sa});
        write_reg(REG_PULSE, {14'd0, ps});
        write_reg(REG_PLONG, {15'd0, pl});
    endtask

    task automatic random_phase(input int n, input bit no_gap);
        item_t it;
        int    r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                it = make_item(OP_LOAD, $urandom_range(0, 15));
            else if (r < 40)
                it = make_item(OP_SAMPLE, $urandom_range(0, 15));
            else if (r < 60)
                it = make_item(OP_RECV, 0);
            else if (r < 85)
                it = make_item(OP_TICK, 0);
            else if (r < 98)
                it = make_item(OP_EXPIRY, $urandom_range(0, 15));
            else begin
                it = make_item(OP_TICK, 0);
                it.op = 3'($urandom_range(5, 7));   // unknown op, ignored
            end
            // Full-range fields now and then so every bit toggles.
            if ($urandom_range(0, 7) == 0) begin
                it.node    = 16'($urandom);
                it.address = 16'($urandom);
            end
            send_item(it, no_gap);
        end
    endtask

    initial begin
        item_t it;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_sink   = 1'b0;
        sink_run    = 1'b0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_config(16'hFFFF, 1'b0, 1'b1, 2'd0, 1'b0);

        // Directed: ports 0..3 inputs (plain, delayed, inverted), the rest outputs on
        // two addresses, some inverted and pulsed.
        for (int p = 0; p < 16; p++) begin
            it = '0;
            it.op = OP_LOAD;
            it.port = p[3:0];
            it.address = (p % 2 == 0) ? 16'hFFFF : 16'h0000;
            it.node = (p == 15) ? 16'h1234 : 16'hFFFF;
            case (p)
                0: it.port_flags = 4'b0001;
                1: it.port_flags = 4'b0011;
                2: it.port_flags = 4'b0101;
                3: it.port_flags = 4'b0111;
                default: it.port_flags = (p % 3 == 0) ? 4'b1000
                                       : ((p % 3 == 1) ? 4'b0100 : 4'b1100);
            endcase
            send_item(it, 1'b0);
        end
        it = make_item(OP_SAMPLE, 0);
        it.start_of_day = 1'b1; it.pin_level = 1'b1; it.tx_ready = 1'b1;
        send_item(it, 1'b0);                                        // start of day, off reported
        it.start_of_day = 1'b0; it.pin_level = 1'b0; send_item(it, 1'b0);   // on
        it.tx_ready = 1'b0; it.pin_level = 1'b1; send_item(it, 1'b0);       // transmit busy
        it = make_item(OP_SAMPLE, 1); it.start_of_day = 1'b0; it.tx_ready = 1'b1;
        it.pin_level = 1'b0; send_item(it, 1'b0);           // delayed input on
        it.pin_level = 1'b1; send_item(it, 1'b0);           // falling starts off delay
        it.pin_level = 1'b0; send_item(it, 1'b0);           // rise while timed
        it.pin_level = 1'b1; send_item(it, 1'b0);
        it = make_item(OP_SAMPLE, 6); send_item(it, 1'b0);  // output port, nothing
        it = make_item(OP_RECV, 0); it.node = 16'hFFFF; it.address = 16'hFFFF;
        it.event_on = 1'b1; send_item(it, 1'b0);            // arms pulse timers
        for (int k = 0; k < 3; k++) begin
            it = make_item(OP_TICK, 0); send_item(it, 1'b0);
        end
        it = make_item(OP_EXPIRY, 1); it.tx_ready = 1'b1; send_item(it, 1'b0);

        // Short events, long pulses.
        set_config(16'h0000, 1'b1, 1'b0, 2'd3, 1'b1);
        random_phase(30, 1'b0);

        // Receiver holds off for a long stretch while the sender keeps offering.
        hold_sink = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_sink = 1'b0;
            end
            random_phase(20, 1'b1);
        join

        set_config(16'h0002, 1'b0, 1'b0, 2'd1, 1'b0);
        sink_run = 1'b1;
        random_phase(25, 1'b0);
        sink_run = 1'b0;
        set_config(16'h0001, 1'b0, 1'b1, 2'd2, 1'b1);
        random_phase(28, 1'b0);

        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: sim.f
rtl/epc_pkg.sv
rtl/epc_stream_if.sv
rtl/epc_table.sv
rtl/event_port_controller.sv
test/epc_checker.sv
test/tb_event_port_controller.sv
